[rtl/eth_vlan_ipv4_l4_header_parser_top_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the Ethernet / VLAN / IPv4 / L4 header parser
// Shared concurrent checks with an active-low reset disable.
// ----------------------------------------------------------------------------
`ifndef ETH_VLAN_IPV4_L4_HEADER_PARSER_TOP_MACROS_SVH
`define ETH_VLAN_IPV4_L4_HEADER_PARSER_TOP_MACROS_SVH

// Same-cycle implication, checked out of reset
`define EVLHP_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset
`define EVLHP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/evlhp_pkg.sv]
// ----------------------------------------------------------------------------
// evlhp_pkg
// Types, field offsets and protocol codes for the header parser.
// ----------------------------------------------------------------------------
`default_nettype none

package evlhp_pkg;

    // Byte position counter width
    localparam int COUNT_WIDTH = 16;

    // Configuration register
    localparam int          DEPTH_WIDTH = 3;
    localparam logic [2:0]  DEPTH_L3    = 3'd3;
    localparam logic [2:0]  DEPTH_L4    = 3'd4;
    localparam logic [2:0]  DEPTH_RESET = 3'd4;

    // Ethernet layout
    localparam int MAC_LEN      = 6;
    localparam int ETYPE_END    = 14;
    localparam int TCI_END      = 16;
    localparam int ETH_HDR_LEN  = 14;
    localparam int VLAN_HDR_LEN = 18;
    localparam int VID_WIDTH    = 12;

    localparam logic [15:0] TPID_8021Q = 16'h8100;
    localparam logic [15:0] ETYPE_IPV4 = 16'h0800;

    // IPv4 layout, offsets from the start of the IPv4 header
    localparam int IP_PROTO_OFF = 9;
    localparam int IP_SRC_OFF   = 12;
    localparam int IP_DST_OFF   = 16;
    localparam int IP_MIN_LEN   = 20;
    localparam int IHL_WIDTH    = 6;

    localparam logic [7:0] PROTO_TCP = 8'd6;
    localparam logic [7:0] PROTO_UDP = 8'd17;

    // L4 layout, offsets from the start of the L4 header
    localparam int L4_DPORT_OFF = 2;
    localparam int L4_PORTS_END = 4;
    localparam int TCP_MIN_LEN  = 20;
    localparam int UDP_MIN_LEN  = 8;

    typedef logic [COUNT_WIDTH-1:0] t_count;
    // Frame length needs one more bit than the saturating position
    typedef logic [COUNT_WIDTH:0]   t_len;

    typedef enum logic [1:0] {
        L4_NONE = 2'd0,
        L4_TCP  = 2'd1,
        L4_UDP  = 2'd2
    } t_l4_kind;

    // Captured fields of one finished frame
    typedef struct packed {
        logic [47:0]          dst_mac;
        logic [47:0]          src_mac;
        logic                 tag_seen;
        logic [VID_WIDTH-1:0] tag_id;
        logic [15:0]          etype;
        logic [IHL_WIDTH-1:0] ip_header_len;
        logic [7:0]           ip_proto;
        logic [31:0]          src_ip;
        logic [31:0]          dst_ip;
        logic [15:0]          src_port;
        logic [15:0]          dst_port;
        t_len                 len;
    } t_snap;

endpackage

`default_nettype wire

[rtl/evlhp_ifs.sv]
// ----------------------------------------------------------------------------
// evlhp channel interfaces
// Valid/ready channels for frame bytes, summary results and configuration.
// ----------------------------------------------------------------------------
`default_nettype none

// Frame byte channel
interface evlhp_pkt_if;
    logic       valid;
    logic       ready;
    logic [7:0] pkt_byte;
    logic       last_byte;

    modport source (output valid, output pkt_byte, output last_byte, input ready);
    modport sink   (input valid, input pkt_byte, input last_byte, output ready);
endinterface

// Summary result channel
interface evlhp_res_if;
    logic        valid;
    logic        ready;
    logic [47:0] dst_mac;
    logic [47:0] src_mac;
    logic        has_vlan;
    logic [11:0] vlan_id;
    logic        is_ipv4;
    logic [31:0] src_ip;
    logic [31:0] dst_ip;
    logic [1:0]  l4_kind;
    logic [15:0] src_port;
    logic [15:0] dst_port;
    logic        drop;

    modport source (
        output valid, output dst_mac, output src_mac, output has_vlan,
        output vlan_id, output is_ipv4, output src_ip, output dst_ip,
        output l4_kind, output src_port, output dst_port, output drop,
        input ready
    );
    modport sink (
        input valid, input dst_mac, input src_mac, input has_vlan,
        input vlan_id, input is_ipv4, input src_ip, input dst_ip,
        input l4_kind, input src_port, input dst_port, input drop,
        output ready
    );
endinterface

// Configuration write channel
interface evlhp_cfg_if;
    logic       valid;
    logic       ready;
    logic [2:0] parse_depth;

    modport source (output valid, output parse_depth, input ready);
    modport sink   (input valid, input parse_depth, output ready);
endinterface

`default_nettype wire

[rtl/evlhp_capture.sv]
// ----------------------------------------------------------------------------
// evlhp_capture
// Positional field capture, one frame byte per cycle while i_pkt.ready is high; snapshot on last byte.
// ----------------------------------------------------------------------------
`default_nettype none

module evlhp_capture (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    evlhp_pkt_if.sink            i_pkt,
    output evlhp_pkg::t_snap     o_snap,
    output logic                 o_snap_valid,
    input  wire logic            i_snap_ready
);

    localparam evlhp_pkg::t_count CountMax = {evlhp_pkg::COUNT_WIDTH{1'b1}};

    // Per-frame state
    evlhp_pkg::t_count                 r_count;
    logic [47:0]                       r_dst_mac, n_dst_mac;
    logic [47:0]                       r_src_mac, n_src_mac;
    logic [15:0]                       r_etype, n_etype;
    logic                              r_tag, n_tag;
    logic [evlhp_pkg::VID_WIDTH-1:0]   r_tag_id, n_tag_id;
    logic [evlhp_pkg::IHL_WIDTH-1:0]   r_ihl, n_ihl;
    logic [7:0]                        r_proto, n_proto;
    logic [31:0]                       r_src_ip, n_src_ip;
    logic [31:0]                       r_dst_ip, n_dst_ip;
    logic [15:0]                       r_sport, n_sport;
    logic [15:0]                       r_dport, n_dport;

    evlhp_pkg::t_snap r_snap;
    logic             r_snap_valid;

    evlhp_pkg::t_len  pos;
    evlhp_pkg::t_len  base;
    evlhp_pkg::t_len  l4;
    logic [7:0]       b;
    logic             accept;

    assign i_pkt.ready = !r_snap_valid || i_snap_ready;
    assign accept      = i_pkt.valid && i_pkt.ready;
    assign b           = i_pkt.pkt_byte;
    assign pos         = {1'b0, r_count};

    // Update captured fields from the byte at the current position
    always_comb begin
        n_dst_mac = r_dst_mac;
        n_src_mac = r_src_mac;
        n_etype   = r_etype;
        n_tag     = r_tag;
        n_tag_id  = r_tag_id;
        n_ihl     = r_ihl;
        n_proto   = r_proto;
        n_src_ip  = r_src_ip;
        n_dst_ip  = r_dst_ip;
        n_sport   = r_sport;
        n_dport   = r_dport;

        // Ethernet and tag fields
        if (pos < evlhp_pkg::t_len'(evlhp_pkg::MAC_LEN)) begin
            n_dst_mac = {r_dst_mac[39:0], b};
        end else if (pos < evlhp_pkg::t_len'(2 * evlhp_pkg::MAC_LEN)) begin
            n_src_mac = {r_src_mac[39:0], b};
        end else if (pos < evlhp_pkg::t_len'(evlhp_pkg::ETYPE_END)) begin
            n_etype = {r_etype[7:0], b};
            if (pos == evlhp_pkg::t_len'(evlhp_pkg::ETYPE_END - 1)
                && n_etype == evlhp_pkg::TPID_8021Q) begin
                n_tag = 1'b1;
            end
        end else if (r_tag && pos < evlhp_pkg::t_len'(evlhp_pkg::TCI_END)) begin
            n_tag_id = {r_tag_id[3:0], b};
        end else if (r_tag && pos < evlhp_pkg::t_len'(evlhp_pkg::VLAN_HDR_LEN)) begin
            n_etype = {r_etype[7:0], b};
        end

        base = r_tag ? evlhp_pkg::t_len'(evlhp_pkg::VLAN_HDR_LEN)
                     : evlhp_pkg::t_len'(evlhp_pkg::ETH_HDR_LEN);
        l4   = '0;

        // IPv4 and L4 fields, relative to the network header start
        if (pos >= base) begin
            if (pos == base) begin
                n_ihl = {b[3:0], 2'b00};
            end else if (pos == base + evlhp_pkg::t_len'(evlhp_pkg::IP_PROTO_OFF)) begin
                n_proto = b;
            end else if (pos >= base + evlhp_pkg::t_len'(evlhp_pkg::IP_SRC_OFF)
                         && pos < base + evlhp_pkg::t_len'(evlhp_pkg::IP_DST_OFF)) begin
                n_src_ip = {r_src_ip[23:0], b};
            end else if (pos >= base + evlhp_pkg::t_len'(evlhp_pkg::IP_DST_OFF)
                         && pos < base + evlhp_pkg::t_len'(evlhp_pkg::IP_MIN_LEN)) begin
                n_dst_ip = {r_dst_ip[23:0], b};
            end

            l4 = base + evlhp_pkg::t_len'(n_ihl);
            if (pos >= l4) begin
                if (pos < l4 + evlhp_pkg::t_len'(evlhp_pkg::L4_DPORT_OFF)) begin
                    n_sport = {r_sport[7:0], b};
                end else if (pos < l4 + evlhp_pkg::t_len'(evlhp_pkg::L4_PORTS_END)) begin
                    n_dport = {r_dport[7:0], b};
                end
            end
        end
    end

    // Advance the frame state; clear it after the last byte
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= '0;
            r_dst_mac <= '0;
            r_src_mac <= '0;
            r_etype   <= '0;
            r_tag     <= 1'b0;
            r_tag_id  <= '0;
            r_ihl     <= '0;
            r_proto   <= '0;
            r_src_ip  <= '0;
            r_dst_ip  <= '0;
            r_sport   <= '0;
            r_dport   <= '0;
        end else if (accept) begin
            if (i_pkt.last_byte) begin
                r_count   <= '0;
                r_dst_mac <= '0;
                r_src_mac <= '0;
                r_etype   <= '0;
                r_tag     <= 1'b0;
                r_tag_id  <= '0;
                r_ihl     <= '0;
                r_proto   <= '0;
                r_src_ip  <= '0;
                r_dst_ip  <= '0;
                r_sport   <= '0;
                r_dport   <= '0;
            end else begin
                if (r_count != CountMax) begin
                    r_count <= r_count + 1'b1;
                end
                r_dst_mac <= n_dst_mac;
                r_src_mac <= n_src_mac;
                r_etype   <= n_etype;
                r_tag     <= n_tag;
                r_tag_id  <= n_tag_id;
                r_ihl     <= n_ihl;
                r_proto   <= n_proto;
                r_src_ip  <= n_src_ip;
                r_dst_ip  <= n_dst_ip;
                r_sport   <= n_sport;
                r_dport   <= n_dport;
            end
        end
    end

    // Hold the finished frame until the emit stage takes it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_snap_valid <= 1'b0;
        end else if (accept && i_pkt.last_byte) begin
            r_snap_valid <= 1'b1;
        end else if (i_snap_ready) begin
            r_snap_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && i_pkt.last_byte) begin
            r_snap.dst_mac       <= n_dst_mac;
            r_snap.src_mac       <= n_src_mac;
            r_snap.tag_seen      <= n_tag;
            r_snap.tag_id        <= n_tag_id;
            r_snap.etype         <= n_etype;
            r_snap.ip_header_len <= n_ihl;
            r_snap.ip_proto      <= n_proto;
            r_snap.src_ip        <= n_src_ip;
            r_snap.dst_ip        <= n_dst_ip;
            r_snap.src_port      <= n_sport;
            r_snap.dst_port      <= n_dport;
            r_snap.len           <= pos + 1'b1;
        end
    end

    assign o_snap       = r_snap;
    assign o_snap_valid = r_snap_valid;

endmodule

`default_nettype wire

[rtl/evlhp_emit.sv]
// ----------------------------------------------------------------------------
// evlhp_emit
// Length checks and field qualification of a finished frame; result register.
// ----------------------------------------------------------------------------
`default_nettype none

`include "eth_vlan_ipv4_l4_header_parser_top_macros.svh"

module evlhp_emit (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    evlhp_cfg_if.sink                i_cfg,
    input  wire evlhp_pkg::t_snap    i_snap,
    input  wire logic                i_snap_valid,
    output logic                     o_snap_ready,
    evlhp_res_if.source              o_res
);

    logic [evlhp_pkg::DEPTH_WIDTH-1:0] r_depth;

    logic                r_valid;
    logic [47:0]         r_dst_mac, n_dst_mac;
    logic [47:0]         r_src_mac, n_src_mac;
    logic                r_vlan, n_vlan;
    logic [11:0]         r_vid, n_vid;
    logic                r_is_ip, n_is_ip;
    logic [31:0]         r_src_ip, n_src_ip;
    logic [31:0]         r_dst_ip, n_dst_ip;
    evlhp_pkg::t_l4_kind r_kind, n_kind;
    logic [15:0]         r_sport, n_sport;
    logic [15:0]         r_dport, n_dport;
    logic                r_drop, n_drop;

    evlhp_pkg::t_len     base;
    evlhp_pkg::t_len     l4;
    logic                take;

    assign i_cfg.ready  = 1'b1;
    assign o_snap_ready = !r_valid || o_res.ready;
    assign take         = i_snap_valid && o_snap_ready;

    // Hold the parse depth register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_depth <= evlhp_pkg::DEPTH_RESET;
        end else if (i_cfg.valid) begin
            r_depth <= i_cfg.parse_depth;
        end
    end

    // Check lengths and qualify fields
    always_comb begin
        base = i_snap.tag_seen ? evlhp_pkg::t_len'(evlhp_pkg::VLAN_HDR_LEN)
                               : evlhp_pkg::t_len'(evlhp_pkg::ETH_HDR_LEN);
        l4   = base + evlhp_pkg::t_len'(i_snap.ip_header_len);

        n_drop  = (i_snap.len < evlhp_pkg::t_len'(evlhp_pkg::ETH_HDR_LEN))
                  || (i_snap.tag_seen
                      && i_snap.len < evlhp_pkg::t_len'(evlhp_pkg::VLAN_HDR_LEN));
        n_is_ip = 1'b0;
        n_kind  = evlhp_pkg::L4_NONE;

        if (!n_drop && r_depth >= evlhp_pkg::DEPTH_L3
            && i_snap.etype == evlhp_pkg::ETYPE_IPV4) begin
            n_is_ip = 1'b1;
            if (i_snap.len < base + evlhp_pkg::t_len'(evlhp_pkg::IP_MIN_LEN)) begin
                n_drop = 1'b1;
            end
        end

        if (!n_drop && n_is_ip && r_depth >= evlhp_pkg::DEPTH_L4) begin
            if (i_snap.ip_proto == evlhp_pkg::PROTO_TCP) begin
                if (i_snap.len < l4 + evlhp_pkg::t_len'(evlhp_pkg::TCP_MIN_LEN)) begin
                    n_drop = 1'b1;
                end else begin
                    n_kind = evlhp_pkg::L4_TCP;
                end
            end else if (i_snap.ip_proto == evlhp_pkg::PROTO_UDP) begin
                if (i_snap.len < l4 + evlhp_pkg::t_len'(evlhp_pkg::UDP_MIN_LEN)) begin
                    n_drop = 1'b1;
                end else begin
                    n_kind = evlhp_pkg::L4_UDP;
                end
            end
        end

        // Zero everything but the drop flag on a short frame
        n_dst_mac = n_drop ? '0 : i_snap.dst_mac;
        n_src_mac = n_drop ? '0 : i_snap.src_mac;
        n_vlan    = !n_drop && i_snap.tag_seen;
        n_vid     = n_vlan ? i_snap.tag_id : '0;
        n_is_ip   = !n_drop && n_is_ip;
        n_src_ip  = n_is_ip ? i_snap.src_ip : '0;
        n_dst_ip  = n_is_ip ? i_snap.dst_ip : '0;
        if (n_drop) begin
            n_kind = evlhp_pkg::L4_NONE;
        end
        n_sport   = (n_kind != evlhp_pkg::L4_NONE) ? i_snap.src_port : '0;
        n_dport   = (n_kind != evlhp_pkg::L4_NONE) ? i_snap.dst_port : '0;
    end

    // Result register valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (take) begin
            r_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_valid <= 1'b0;
        end
    end

    // Result register payload
    always_ff @(posedge i_clk) begin
        if (take) begin
            r_dst_mac <= n_dst_mac;
            r_src_mac <= n_src_mac;
            r_vlan    <= n_vlan;
            r_vid     <= n_vid;
            r_is_ip   <= n_is_ip;
            r_src_ip  <= n_src_ip;
            r_dst_ip  <= n_dst_ip;
            r_kind    <= n_kind;
            r_sport   <= n_sport;
            r_dport   <= n_dport;
            r_drop    <= n_drop;
        end
    end

    assign o_res.valid        = r_valid;
    assign o_res.dst_mac      = r_dst_mac;
    assign o_res.src_mac      = r_src_mac;
    assign o_res.has_vlan     = r_vlan;
    assign o_res.vlan_id      = r_vid;
    assign o_res.is_ipv4      = r_is_ip;
    assign o_res.src_ip       = r_src_ip;
    assign o_res.dst_ip       = r_dst_ip;
    assign o_res.l4_kind      = r_kind;
    assign o_res.src_port     = r_sport;
    assign o_res.dst_port     = r_dport;
    assign o_res.drop         = r_drop;

    `EVLHP_ASSERT_NOW(a_drop_clears_fields, i_clk, i_rst_n, r_valid && r_drop, r_dst_mac == '0 && r_src_mac == '0 && !r_vlan && !r_is_ip && r_kind == evlhp_pkg::L4_NONE, "dropped frame carries fields")
    `EVLHP_ASSERT_NOW(a_l4_needs_ipv4, i_clk, i_rst_n, r_valid && r_kind != evlhp_pkg::L4_NONE, r_is_ip && r_depth >= evlhp_pkg::DEPTH_L4, "L4 kind without IPv4 at full depth")
    `EVLHP_ASSERT_NOW(a_no_ports_without_l4, i_clk, i_rst_n, r_valid && r_kind == evlhp_pkg::L4_NONE, r_sport == '0 && r_dport == '0, "ports set with no L4 kind")
    `EVLHP_ASSERT_NEXT(a_take_loads_result, i_clk, i_rst_n, take, r_valid, "snapshot taken but no result held")

endmodule

`default_nettype wire

[rtl/eth_vlan_ipv4_l4_header_parser_top.sv]
// ----------------------------------------------------------------------------
// eth_vlan_ipv4_l4_header_parser_top
// Streaming Ethernet / 802.1Q / IPv4 / TCP-UDP header summary.
// ----------------------------------------------------------------------------
// Usage:
//   i_pkt carries one frame byte per item, in wire order, with last_byte set
//   on the final byte. Fields are captured by byte position as they pass.
//   o_res carries one summary item per frame, produced after its last byte.
//   i_cfg writes parse_depth (2 Ethernet, 3 adds IPv4, 4 adds L4 ports);
//   write it only while no frame is in flight. It is always ready.
// Throughput: one byte per cycle while i_pkt.ready is high; the capture
//   logic updates every field combinationally, so bytes stream back to back.
// Result path: the finished frame passes the snapshot register, then the
//   result register, before the result item is valid.
// Stall: while o_res is held off, the block keeps taking bytes; once both
//   the snapshot and the result register hold finished frames, i_pkt.ready
//   drops until the receiver takes a result.
// Reset: synchronous, active low; clears all frame state, drops any pending
//   results and sets parse_depth to 4.
// ----------------------------------------------------------------------------
`default_nettype none

module eth_vlan_ipv4_l4_header_parser_top (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    evlhp_pkt_if.sink   i_pkt,
    evlhp_cfg_if.sink   i_cfg,
    evlhp_res_if.source o_res
);

    evlhp_pkg::t_snap snap;
    logic             snap_valid;
    logic             snap_ready;

    // Positional capture
    evlhp_capture u_capture (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_pkt        (i_pkt),
        .o_snap       (snap),
        .o_snap_valid (snap_valid),
        .i_snap_ready (snap_ready)
    );

    // Length checks and result register
    evlhp_emit u_emit (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (i_cfg),
        .i_snap       (snap),
        .i_snap_valid (snap_valid),
        .o_snap_ready (snap_ready),
        .o_res        (o_res)
    );

endmodule

`default_nettype wire
